@@ hdl/quadrotor_attitude_pd_mixer_macros.svh @@
// Assertion macros for the quadrotor attitude PD mixer.
// Included by the port checker; needs nothing else.
`ifndef QUADROTOR_ATTITUDE_PD_MIXER_MACROS_SVH
`define QUADROTOR_ATTITUDE_PD_MIXER_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define QAPM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition that holds at every rising edge outside reset.
`define QAPM_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

@@ hdl/qapm_pkg.sv @@
// Shared types, constants and register codes of the attitude PD mixer.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package qapm_pkg;

  // Field widths
  localparam int CH_W     = 12;          // receiver channels
  localparam int ANG_W    = 13;          // attitude angles, signed
  localparam int RATE_W   = 16;          // body rates, signed
  localparam int MOTOR_W  = 15;          // motor commands, signed
  localparam int HOVER_W  = 10;
  localparam int LVL_W    = 2;
  localparam int SPAN_W   = 12;
  localparam int OFS_W    = CH_W + 1;    // signed stick offset from centre
  localparam int THR_W    = CH_W + 1;    // throttle plus hover offset

  // Configuration port
  localparam int REG_IDX_W = 3;
  localparam int ADDR_W    = REG_IDX_W + 2;
  localparam int DATA_W    = 32;

  localparam logic [REG_IDX_W-1:0] REG_CONTROL_LEVEL  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PILOT_SWITCHED = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_STICK_CENTRE   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_STICK_LOWEST   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_STICK_HIGHEST  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_HOVER_OFFSET   = 3'd5;

  localparam logic [CH_W-1:0]    RST_STICK_CENTRE  = 12'd1496;
  localparam logic [CH_W-1:0]    RST_STICK_LOWEST  = 12'd992;
  localparam logic [CH_W-1:0]    RST_STICK_HIGHEST = 12'd2000;
  localparam logic [HOVER_W-1:0] RST_HOVER_OFFSET  = 10'd488;

  // Control levels
  localparam logic [LVL_W-1:0] LVL_ACRO = 2'd0;
  localparam logic [LVL_W-1:0] LVL_HOLD = 2'd1;
  localparam logic [LVL_W-1:0] LVL_YAW  = 2'd2;
  localparam logic [LVL_W-1:0] LVL_RSVD = 2'd3;

  // Loop constants. A full stick span maps to +/-30 deg, i.e. 960 sixteenths
  // per span; doubled here because the roll and pitch P gain is 2.
  localparam int PD_KP      = 2;
  localparam int PD_KD      = 10;
  localparam int CMD_SCALE  = 1920;
  // Yaw: P gain 50 times +/-50 deg/s per span, in sixteenths: 50*100*16.
  localparam int YAW_KP     = 50;
  localparam int YAW_SCALE  = 80000;
  localparam int CLAMP_LIM  = 500;

  // Divider: biased quotient lies in 0..1000
  localparam int QUOT_BITS  = 10;
  localparam int QUOT_BIAS  = 500;
  localparam int NUM_W      = 36;
  localparam int D_W        = SPAN_W + 4;
  localparam int DIV_W      = D_W + 1;
  localparam int REM_W      = 27;

  // Cycles from the accepting edge to the edge that takes the result
  localparam int RESULT_LATENCY = QUOT_BITS + 5;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [LVL_W-1:0]         control_level;
    logic                     pilot_switched;
    logic [CH_W-1:0]          centre;
    logic [CH_W-1:0]          lowest;
    logic [CH_W-1:0]          highest;
    logic [HOVER_W-1:0]       hover;
  } cfg_t;

  // One classified sample as it travels from front to back
  typedef struct packed {
    logic [LVL_W-1:0]         level;
    logic [THR_W-1:0]         thrust;
    logic signed [OFS_W-1:0]  ofs_ail;
    logic signed [OFS_W-1:0]  ofs_ele;
    logic signed [OFS_W-1:0]  ofs_rud;
    logic [SPAN_W-1:0]        span;
    logic signed [ANG_W-1:0]  roll;
    logic signed [ANG_W-1:0]  pitch;
    logic signed [RATE_W-1:0] prate;
    logic signed [RATE_W-1:0] qrate;
    logic signed [RATE_W-1:0] rrate;
    logic [CH_W-1:0]          arm;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

endpackage

`default_nettype wire

@@ hdl/qapm_regs.sv @@
// Configuration registers and their APB-style access port.
// Depends on qapm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qapm_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [qapm_pkg::ADDR_W-1:0]  paddr,
  input  logic [qapm_pkg::DATA_W-1:0]  pwdata,
  output logic [qapm_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output qapm_pkg::cfg_t               cfg
);

  logic [qapm_pkg::LVL_W-1:0]   control_level_r;
  logic                         pilot_switched_r;
  logic [qapm_pkg::CH_W-1:0]    centre_r;
  logic [qapm_pkg::CH_W-1:0]    lowest_r;
  logic [qapm_pkg::CH_W-1:0]    highest_r;
  logic [qapm_pkg::HOVER_W-1:0] hover_r;
  logic [qapm_pkg::REG_IDX_W-1:0] reg_idx;
  logic                         wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[qapm_pkg::ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;

  // A write transfer lands in the access cycle; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      control_level_r  <= qapm_pkg::LVL_ACRO;
      pilot_switched_r <= 1'b0;
      centre_r         <= qapm_pkg::RST_STICK_CENTRE;
      lowest_r         <= qapm_pkg::RST_STICK_LOWEST;
      highest_r        <= qapm_pkg::RST_STICK_HIGHEST;
      hover_r          <= qapm_pkg::RST_HOVER_OFFSET;
    end else if (wr_en) begin
      unique case (reg_idx)
        qapm_pkg::REG_CONTROL_LEVEL:  control_level_r  <= pwdata[qapm_pkg::LVL_W-1:0];
        qapm_pkg::REG_PILOT_SWITCHED: pilot_switched_r <= pwdata[0];
        qapm_pkg::REG_STICK_CENTRE:   centre_r         <= pwdata[qapm_pkg::CH_W-1:0];
        qapm_pkg::REG_STICK_LOWEST:   lowest_r         <= pwdata[qapm_pkg::CH_W-1:0];
        qapm_pkg::REG_STICK_HIGHEST:  highest_r        <= pwdata[qapm_pkg::CH_W-1:0];
        qapm_pkg::REG_HOVER_OFFSET:   hover_r          <= pwdata[qapm_pkg::HOVER_W-1:0];
        default: ;
      endcase
    end
  end

  // Read data
  always_comb begin
    unique case (reg_idx)
      qapm_pkg::REG_CONTROL_LEVEL:  prdata = qapm_pkg::DATA_W'(control_level_r);
      qapm_pkg::REG_PILOT_SWITCHED: prdata = qapm_pkg::DATA_W'(pilot_switched_r);
      qapm_pkg::REG_STICK_CENTRE:   prdata = qapm_pkg::DATA_W'(centre_r);
      qapm_pkg::REG_STICK_LOWEST:   prdata = qapm_pkg::DATA_W'(lowest_r);
      qapm_pkg::REG_STICK_HIGHEST:  prdata = qapm_pkg::DATA_W'(highest_r);
      qapm_pkg::REG_HOVER_OFFSET:   prdata = qapm_pkg::DATA_W'(hover_r);
      default:                      prdata = '0;
    endcase
  end

  assign cfg.control_level  = control_level_r;
  assign cfg.pilot_switched = pilot_switched_r;
  assign cfg.centre         = centre_r;
  assign cfg.lowest         = lowest_r;
  assign cfg.highest        = highest_r;
  assign cfg.hover          = hover_r;

endmodule

`default_nettype wire

@@ hdl/qapm_front.sv @@
// Front end: takes a sample, settles its effective control level, stick
// offsets, span and thrust, and hands it to the queue. Depends on qapm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qapm_front (
  input  logic                               start,
  output logic                               busy,
  input  logic [qapm_pkg::CH_W-1:0]          in_throttle_stick,
  input  logic [qapm_pkg::CH_W-1:0]          in_aileron_stick,
  input  logic [qapm_pkg::CH_W-1:0]          in_elevator_stick,
  input  logic [qapm_pkg::CH_W-1:0]          in_rudder_stick,
  input  logic [qapm_pkg::CH_W-1:0]          in_arm_channel,
  input  logic [qapm_pkg::CH_W-1:0]          in_autopilot_channel,
  input  logic signed [qapm_pkg::ANG_W-1:0]  in_roll_angle,
  input  logic signed [qapm_pkg::ANG_W-1:0]  in_pitch_angle,
  input  logic signed [qapm_pkg::RATE_W-1:0] in_roll_gyro,
  input  logic signed [qapm_pkg::RATE_W-1:0] in_pitch_gyro,
  input  logic signed [qapm_pkg::RATE_W-1:0] in_yaw_gyro,
  input  qapm_pkg::cfg_t                     cfg,
  input  qapm_pkg::qstat_t                   qstat,
  output logic                               push,
  output qapm_pkg::item_t                    item
);

  logic [qapm_pkg::LVL_W-1:0]       level;
  logic signed [qapm_pkg::CH_W:0]   span_raw;
  logic signed [qapm_pkg::OFS_W-1:0] centre_s;

  // Take a transfer whenever the queue has room
  assign busy = qstat.full;
  assign push = start & ~qstat.full;

  // Effective level: acro if switched and autopilot <= centre, or if reserved
  always_comb begin
    level = cfg.control_level;
    if (cfg.pilot_switched && !(in_autopilot_channel > cfg.centre)) begin
      level = qapm_pkg::LVL_ACRO;
    end
    if (level == qapm_pkg::LVL_RSVD) begin
      level = qapm_pkg::LVL_ACRO;
    end
  end

  // Stick span, taken as one when the limits are empty or inverted
  assign span_raw = $signed({1'b0, cfg.highest}) - $signed({1'b0, cfg.lowest});
  assign centre_s = $signed({1'b0, cfg.centre});

  always_comb begin
    item.level   = level;
    item.thrust  = {1'b0, in_throttle_stick}
                 + {{(qapm_pkg::THR_W - qapm_pkg::HOVER_W){1'b0}}, cfg.hover};
    item.ofs_ail = $signed({1'b0, in_aileron_stick}) - centre_s;
    item.ofs_ele = $signed({1'b0, in_elevator_stick}) - centre_s;
    item.ofs_rud = $signed({1'b0, in_rudder_stick}) - centre_s;
    if (span_raw[qapm_pkg::CH_W] || (span_raw == '0)) begin
      item.span = qapm_pkg::SPAN_W'(1);
    end else begin
      item.span = span_raw[qapm_pkg::SPAN_W-1:0];
    end
    item.roll    = in_roll_angle;
    item.pitch   = in_pitch_angle;
    item.prate   = in_roll_gyro;
    item.qrate   = in_pitch_gyro;
    item.rrate   = in_yaw_gyro;
    item.arm     = in_arm_channel;
  end

endmodule

`default_nettype wire

@@ hdl/qapm_queue.sv @@
// Short queue of classified samples between the front and back ends.
// Depends on qapm_pkg; DEPTH must be at least two.
`timescale 1ns / 1ps
`default_nettype none

module qapm_queue #(
  parameter int DEPTH = qapm_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  qapm_pkg::item_t  push_item,
  input  logic             pop,
  output qapm_pkg::item_t  pop_item,
  output qapm_pkg::qstat_t qstat
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  qapm_pkg::item_t  slot_r [0:DEPTH-1];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  assign pop_item    = slot_r[rd_ptr_r];
  assign qstat.empty = (cnt_r == '0);
  assign qstat.full  = (cnt_r == CNT_W'(DEPTH));

endmodule

`default_nettype wire

@@ hdl/qapm_back.sv @@
// Back end: products, PD and yaw numerators, clamp test, a pipelined
// restoring divider per axis (one quotient bit a stage) and the motor mix.
// Depends on qapm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qapm_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  qapm_pkg::qstat_t                    qstat,
  input  qapm_pkg::item_t                     head,
  output logic                                pop,
  output logic                                out_strobe,
  output logic signed [qapm_pkg::MOTOR_W-1:0] out_motor_rear_right,
  output logic signed [qapm_pkg::MOTOR_W-1:0] out_motor_front_right,
  output logic signed [qapm_pkg::MOTOR_W-1:0] out_motor_rear_left,
  output logic signed [qapm_pkg::MOTOR_W-1:0] out_motor_front_left,
  output logic [qapm_pkg::CH_W-1:0]           out_arm_out
);

  localparam int QB      = qapm_pkg::QUOT_BITS;
  localparam int NUM_W   = qapm_pkg::NUM_W;
  localparam int REM_W   = qapm_pkg::REM_W;
  localparam int OFS_W   = qapm_pkg::OFS_W;
  localparam int ANGP_W  = qapm_pkg::ANG_W + qapm_pkg::SPAN_W + 1;
  localparam int RATEP_W = qapm_pkg::RATE_W + qapm_pkg::SPAN_W + 1;
  localparam int STKP_W  = OFS_W + 11;
  localparam int YAWP_W  = OFS_W + 17;
  localparam int CR_W    = QB + 2;
  localparam int SUM_W   = 16;
  localparam int MW      = qapm_pkg::MOTOR_W;
  localparam int NLANE   = 3;
  localparam int L_ROLL  = 0;
  localparam int L_PITCH = 1;
  localparam int L_YAW   = 2;

  localparam logic signed [SUM_W-1:0] MOT_HI = SUM_W'(2 ** (MW - 1) - 1);
  localparam logic signed [SUM_W-1:0] MOT_LO = -SUM_W'(2 ** (MW - 1));

  // Fields that ride alongside the arithmetic
  typedef struct packed {
    logic [qapm_pkg::LVL_W-1:0] level;
    logic [qapm_pkg::THR_W-1:0] thrust;
    logic signed [OFS_W-1:0]    ofs_ail;
    logic signed [OFS_W-1:0]    ofs_ele;
    logic signed [OFS_W-1:0]    ofs_rud;
    logic [qapm_pkg::CH_W-1:0]  arm;
  } side_t;

  function automatic logic signed [MW-1:0] sat_motor(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] c;
    c = v;
    if (v > MOT_HI) begin
      c = MOT_HI;
    end else if (v < MOT_LO) begin
      c = MOT_LO;
    end
    return c[MW-1:0];
  endfunction

  // Stage 0 registers: products
  logic                               vld0_r;
  side_t                              side0_r;
  logic [qapm_pkg::SPAN_W-1:0]        span0_r;
  logic signed [ANGP_W-1:0]           roll_sp_r, pitch_sp_r;
  logic signed [RATEP_W-1:0]          prate_sp_r, qrate_sp_r, rrate_sp_r;
  logic signed [STKP_W-1:0]           ail_cmd_r, ele_cmd_r;
  logic signed [YAWP_W-1:0]           rud_cmd_r;
  logic signed [ANGP_W-1:0]           span_s;

  // Stage 1 registers: numerators and the denominator d = 16 * span
  logic                               vld1_r;
  side_t                              side1_r;
  logic [qapm_pkg::D_W-1:0]           d1_r;
  logic signed [NUM_W-1:0]            num_r [0:NLANE-1];

  // Divider stages; index 0 holds the clamp test and the biased numerator
  logic                               vld_r  [0:QB];
  side_t                              side_r [0:QB];
  logic [qapm_pkg::DIV_W-1:0]         dv_r   [0:QB];
  logic [REM_W-1:0]                   rem_r  [0:QB][0:NLANE-1];
  logic [QB-1:0]                      quot_r [0:QB][0:NLANE-1];
  logic                               hi_r   [0:QB][0:NLANE-1];
  logic                               lo_r   [0:QB][0:NLANE-1];
  logic [REM_W-1:0]                   rem_nxt  [0:QB][0:NLANE-1];
  logic [QB-1:0]                      quot_nxt [0:QB][0:NLANE-1];
  logic                               hi_nxt   [0:QB][0:NLANE-1];
  logic                               lo_nxt   [0:QB][0:NLANE-1];

  // Result mix
  logic signed [CR_W-1:0]             cr [0:NLANE-1];
  logic signed [OFS_W-1:0]            droll, dpitch, dyaw;
  logic signed [SUM_W-1:0]            t_s, dr_s, dp_s, dy_s;
  side_t                              fin;

  // The back end never stalls, so it drains the queue whenever it holds data
  assign pop    = ~qstat.empty;
  assign span_s = ANGP_W'($signed({1'b0, head.span}));

  // Stage 0: one multiplier per product
  always_ff @(posedge clk) begin
    side0_r.level   <= head.level;
    side0_r.thrust  <= head.thrust;
    side0_r.ofs_ail <= head.ofs_ail;
    side0_r.ofs_ele <= head.ofs_ele;
    side0_r.ofs_rud <= head.ofs_rud;
    side0_r.arm     <= head.arm;
    span0_r         <= head.span;
    roll_sp_r       <= ANGP_W'(head.roll) * span_s;
    pitch_sp_r      <= ANGP_W'(head.pitch) * span_s;
    prate_sp_r      <= RATEP_W'(head.prate) * RATEP_W'(span_s);
    qrate_sp_r      <= RATEP_W'(head.qrate) * RATEP_W'(span_s);
    rrate_sp_r      <= RATEP_W'(head.rrate) * RATEP_W'(span_s);
    ail_cmd_r       <= STKP_W'(head.ofs_ail) * STKP_W'(qapm_pkg::CMD_SCALE);
    ele_cmd_r       <= STKP_W'(head.ofs_ele) * STKP_W'(qapm_pkg::CMD_SCALE);
    rud_cmd_r       <= YAWP_W'(head.ofs_rud) * YAWP_W'(qapm_pkg::YAW_SCALE);
  end

  // Stage 1: roll and pitch PD and yaw P numerators over the common 16*span
  always_ff @(posedge clk) begin
    side1_r        <= side0_r;
    d1_r           <= {span0_r, 4'b0000};
    num_r[L_ROLL]  <= NUM_W'(roll_sp_r) * NUM_W'(qapm_pkg::PD_KP)
                    + NUM_W'(prate_sp_r) * NUM_W'(qapm_pkg::PD_KD)
                    - NUM_W'(ail_cmd_r);
    num_r[L_PITCH] <= NUM_W'(pitch_sp_r) * NUM_W'(qapm_pkg::PD_KP)
                    + NUM_W'(qrate_sp_r) * NUM_W'(qapm_pkg::PD_KD)
                    + NUM_W'(ele_cmd_r);
    num_r[L_YAW]   <= NUM_W'(rrate_sp_r) * NUM_W'(qapm_pkg::YAW_KP)
                    - NUM_W'(rud_cmd_r);
  end

  // Clamp test and divider steps. Outside the clamp the rounded quotient
  // floor((2n+d)/(2d)) is found as floor((2n+1001d)/(2d)) - 500, which is
  // non-negative and below 1024.
  always_comb begin
    logic signed [NUM_W-1:0] dw;
    logic signed [NUM_W-1:0] lim;
    logic signed [NUM_W-1:0] nb;
    logic [REM_W-1:0]        dsh;
    dw  = NUM_W'($signed({1'b0, d1_r}));
    lim = dw * NUM_W'(qapm_pkg::CLAMP_LIM);
    for (int l = 0; l < NLANE; l++) begin
      nb             = (num_r[l] <<< 1) + dw * NUM_W'(2 * qapm_pkg::QUOT_BIAS + 1);
      hi_nxt[0][l]   = (num_r[l] >= lim);
      lo_nxt[0][l]   = (num_r[l] <= -lim);
      rem_nxt[0][l]  = nb[REM_W-1:0];
      quot_nxt[0][l] = '0;
    end
    for (int j = 0; j < QB; j++) begin
      dsh = REM_W'(dv_r[j]) << (QB - 1 - j);
      for (int l = 0; l < NLANE; l++) begin
        hi_nxt[j+1][l] = hi_r[j][l];
        lo_nxt[j+1][l] = lo_r[j][l];
        if (rem_r[j][l] >= dsh) begin
          rem_nxt[j+1][l]  = rem_r[j][l] - dsh;
          quot_nxt[j+1][l] = {quot_r[j][l][QB-2:0], 1'b1};
        end else begin
          rem_nxt[j+1][l]  = rem_r[j][l];
          quot_nxt[j+1][l] = {quot_r[j][l][QB-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= side1_r;
    dv_r[0]   <= {d1_r, 1'b0};
    for (int j = 0; j < QB; j++) begin
      side_r[j+1] <= side_r[j];
      dv_r[j+1]   <= dv_r[j];
    end
    for (int j = 0; j <= QB; j++) begin
      for (int l = 0; l < NLANE; l++) begin
        rem_r[j][l]  <= rem_nxt[j][l];
        quot_r[j][l] <= quot_nxt[j][l];
        hi_r[j][l]   <= hi_nxt[j][l];
        lo_r[j][l]   <= lo_nxt[j][l];
      end
    end
  end

  // Valid flags along the pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r     <= 1'b0;
      vld1_r     <= 1'b0;
      out_strobe <= 1'b0;
      for (int j = 0; j <= QB; j++) begin
        vld_r[j] <= 1'b0;
      end
    end else begin
      vld0_r   <= pop;
      vld1_r   <= vld0_r;
      vld_r[0] <= vld1_r;
      for (int j = 0; j < QB; j++) begin
        vld_r[j+1] <= vld_r[j];
      end
      out_strobe <= vld_r[QB];
    end
  end

  // Clamped, rounded controller outputs
  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      if (hi_r[QB][l]) begin
        cr[l] = CR_W'(qapm_pkg::CLAMP_LIM);
      end else if (lo_r[QB][l]) begin
        cr[l] = -CR_W'(qapm_pkg::CLAMP_LIM);
      end else begin
        cr[l] = $signed({2'b00, quot_r[QB][l]}) - CR_W'(qapm_pkg::QUOT_BIAS);
      end
    end
  end

  // Per-axis corrections by level
  assign fin = side_r[QB];

  always_comb begin
    droll  = fin.ofs_ail;
    dpitch = fin.ofs_ele;
    dyaw   = fin.ofs_rud;
    unique case (fin.level)
      qapm_pkg::LVL_HOLD: begin
        droll  = -OFS_W'(cr[L_ROLL]);
        dpitch = OFS_W'(cr[L_PITCH]);
      end
      qapm_pkg::LVL_YAW: begin
        droll  = -OFS_W'(cr[L_ROLL]);
        dpitch = OFS_W'(cr[L_PITCH]);
        dyaw   = -OFS_W'(cr[L_YAW]);
      end
      default: ;
    endcase
  end

  assign t_s  = $signed({{(SUM_W - qapm_pkg::THR_W){1'b0}}, fin.thrust});
  assign dr_s = SUM_W'(droll);
  assign dp_s = SUM_W'(dpitch);
  assign dy_s = SUM_W'(dyaw);

  // X-frame mix and output register
  always_ff @(posedge clk) begin
    out_motor_rear_right  <= sat_motor(t_s - dr_s + dp_s + dy_s);
    out_motor_front_right <= sat_motor(t_s - dr_s - dp_s - dy_s);
    out_motor_rear_left   <= sat_motor(t_s + dr_s + dp_s - dy_s);
    out_motor_front_left  <= sat_motor(t_s + dr_s - dp_s + dy_s);
    out_arm_out           <= fin.arm;
  end

endmodule

`default_nettype wire

@@ hdl/quadrotor_attitude_pd_mixer.sv @@
// Path: a sample taken at a rising edge passes ten divider stages plus five
// others before its result strobe rises.
// Throughput: one sample every cycle; the back end drains the queue each
// cycle, so busy stays low and results cannot be held off.
// Reset: synchronous, active low; clears the queue and pipeline valids and
// loads the configuration registers with their default values.
`timescale 1ns / 1ps
`default_nettype none

module quadrotor_attitude_pd_mixer #(
  parameter int QUEUE_DEPTH = qapm_pkg::QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [qapm_pkg::CH_W-1:0]           in_throttle_stick,
  input  logic [qapm_pkg::CH_W-1:0]           in_aileron_stick,
  input  logic [qapm_pkg::CH_W-1:0]           in_elevator_stick,
  input  logic [qapm_pkg::CH_W-1:0]           in_rudder_stick,
  input  logic [qapm_pkg::CH_W-1:0]           in_arm_channel,
  input  logic [qapm_pkg::CH_W-1:0]           in_autopilot_channel,
  input  logic signed [qapm_pkg::ANG_W-1:0]   in_roll_angle,
  input  logic signed [qapm_pkg::ANG_W-1:0]   in_pitch_angle,
  input  logic signed [qapm_pkg::RATE_W-1:0]  in_roll_gyro,
  input  logic signed [qapm_pkg::RATE_W-1:0]  in_pitch_gyro,
  input  logic signed [qapm_pkg::RATE_W-1:0]  in_yaw_gyro,
  output logic                                out_strobe,
  output logic signed [qapm_pkg::MOTOR_W-1:0] out_motor_rear_right,
  output logic signed [qapm_pkg::MOTOR_W-1:0] out_motor_front_right,
  output logic signed [qapm_pkg::MOTOR_W-1:0] out_motor_rear_left,
  output logic signed [qapm_pkg::MOTOR_W-1:0] out_motor_front_left,
  output logic [qapm_pkg::CH_W-1:0]           out_arm_out,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [qapm_pkg::ADDR_W-1:0]         paddr,
  input  logic [qapm_pkg::DATA_W-1:0]         pwdata,
  output logic [qapm_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);

  qapm_pkg::cfg_t   cfg;
  qapm_pkg::qstat_t qstat;
  qapm_pkg::item_t  push_item;
  qapm_pkg::item_t  head;
  logic             push;
  logic             pop;

  // Configuration registers
  qapm_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sample intake and classification
  qapm_front u_front (
    .start                (start),
    .busy                 (busy),
    .in_throttle_stick    (in_throttle_stick),
    .in_aileron_stick     (in_aileron_stick),
    .in_elevator_stick    (in_elevator_stick),
    .in_rudder_stick      (in_rudder_stick),
    .in_arm_channel       (in_arm_channel),
    .in_autopilot_channel (in_autopilot_channel),
    .in_roll_angle        (in_roll_angle),
    .in_pitch_angle       (in_pitch_angle),
    .in_roll_gyro         (in_roll_gyro),
    .in_pitch_gyro        (in_pitch_gyro),
    .in_yaw_gyro          (in_yaw_gyro),
    .cfg                  (cfg),
    .qstat                (qstat),
    .push                 (push),
    .item                 (push_item)
  );

  // Decoupling queue
  qapm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (head),
    .qstat     (qstat)
  );

  // Arithmetic pipeline and motor mix
  qapm_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .qstat                 (qstat),
    .head                  (head),
    .pop                   (pop),
    .out_strobe            (out_strobe),
    .out_motor_rear_right  (out_motor_rear_right),
    .out_motor_front_right (out_motor_front_right),
    .out_motor_rear_left   (out_motor_rear_left),
    .out_motor_front_left  (out_motor_front_left),
    .out_arm_out           (out_arm_out)
  );

endmodule

`default_nettype wire

@@ hdl/qapm_checker.sv @@
// Port-level checker for the attitude PD mixer, bound to the top level.
// Depends on qapm_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "quadrotor_attitude_pd_mixer_macros.svh"

module qapm_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic [qapm_pkg::CH_W-1:0] in_arm_channel,
  input logic                      out_strobe,
  input logic [qapm_pkg::CH_W-1:0] out_arm_out
);

  // The back end drains every cycle, so the queue never fills.
  `QAPM_ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy, "busy raised although the back end never stalls")

  // Every accepted transfer produces its result after the fixed latency.
  `QAPM_ASSERT_IMPLY(a_result_follows, clk, rst_n, start && !busy, ##(qapm_pkg::RESULT_LATENCY) out_strobe, "accepted sample gave no result")

  // No result appears without a matching accepted transfer.
  `QAPM_ASSERT_IMPLY(a_no_spurious, clk, rst_n, out_strobe, $past(start && !busy, qapm_pkg::RESULT_LATENCY), "result without an accepted sample")

  // The arm channel travels with its own sample.
  `QAPM_ASSERT_IMPLY(a_arm_aligned, clk, rst_n, out_strobe, out_arm_out == $past(in_arm_channel, qapm_pkg::RESULT_LATENCY), "arm channel out of step with its sample")

endmodule

bind quadrotor_attitude_pd_mixer qapm_checker u_qapm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_arm_channel (in_arm_channel),
  .out_strobe     (out_strobe),
  .out_arm_out    (out_arm_out)
);

`default_nettype wire
